// File: hdl/robust_mean_rms_estimator_assert.svh
// Assertion macros for the robust mean and RMS estimator
`ifndef ROBUST_MEAN_RMS_ESTIMATOR_ASSERT_SVH
`define ROBUST_MEAN_RMS_ESTIMATOR_ASSERT_SVH
`define RMRE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define RMRE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: hdl/rmre_pkg.sv
// Shared types, widths and codes for the robust mean and RMS estimator
`default_nettype none
package rmre_pkg;
  localparam int MAX_SAMPLES = 16;
  localparam int SW   = 24;
  localparam int DW   = 23;
  localparam int OCW  = 5;
  localparam int CW   = $clog2(MAX_SAMPLES + 1);
  localparam int AW   = $clog2(MAX_SAMPLES);
  localparam int SUMW = DW + CW;
  localparam int SQW  = 2 * DW + CW;
  localparam int PSW  = 2 * DW;
  localparam int PW   = 2 * SUMW;
  localparam int RW   = PW / 2;
  localparam int NNW  = 2 * CW;
  localparam int ITW  = $clog2(PW);
  localparam int TW   = RW + 3;

  localparam logic [1:0] MODE_PLAIN = 2'd0;
  localparam logic [1:0] MODE_TRUNC = 2'd1;
  localparam logic [1:0] MODE_CLIP  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_OVF   = 2'd2;

  localparam int OPW = 4;
  localparam logic [OPW-1:0] OP_LDP  = 4'd0;
  localparam logic [OPW-1:0] OP_LDT  = 4'd1;
  localparam logic [OPW-1:0] OP_LDC  = 4'd2;
  localparam logic [OPW-1:0] OP_MX2  = 4'd3;
  localparam logic [OPW-1:0] OP_MA   = 4'd4;
  localparam logic [OPW-1:0] OP_MB   = 4'd5;
  localparam logic [OPW-1:0] OP_NN   = 4'd6;
  localparam logic [OPW-1:0] OP_DQ   = 4'd7;
  localparam logic [OPW-1:0] OP_DM   = 4'd8;
  localparam logic [OPW-1:0] OP_SQ   = 4'd9;
  localparam logic [OPW-1:0] OP_SV1  = 4'd10;
  localparam logic [OPW-1:0] OP_CLIP = 4'd11;
  localparam logic [OPW-1:0] OP_EMIT = 4'd12;

  typedef struct packed {
    logic signed [SW-1:0] sample;
    logic                 last_sample;
  } in_t;

  typedef struct packed {
    logic [1:0]     status;
    logic [OCW-1:0] used_count;
    logic [DW-1:0]  mean_value;
    logic [DW-1:0]  rms_value;
  } out_t;

  typedef struct packed {
    logic           take;
    logic           go;
    logic [OPW-1:0] op;
    logic           ok;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic ge1;
    logic ge2;
    logic gn_zero;
  } sts_t;
endpackage
`default_nettype wire

// File: hdl/rmre_ram.sv
// Generic single-write, single-read RAM with registered read
`default_nettype none
module rmre_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: hdl/rmre_dp.sv
// Datapath: accumulators, sample store, serial multiply, divide and root unit
`default_nettype none
module rmre_dp import rmre_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire in_t  in_word,
  input  wire cmd_t cmd,
  output sts_t      sts,
  output out_t      out_word,
  output logic      out_valid
);
  logic           run_r, run_nxt, done_r, done_nxt, oval_r, oval_nxt;
  logic [OPW-1:0] op_r, op_nxt;
  logic [ITW-1:0] cnt_r, cnt_nxt;
  logic [1:0]     ph_r, ph_nxt;
  logic [AW-1:0]  idx_r, idx_nxt;
  logic [CW-1:0]  nsmp_r, nsmp_nxt;
  logic [SUMW-1:0] sum_r, sum_nxt;
  logic [SQW-1:0] sq_r, sq_nxt;
  logic [DW-1:0]  mx_r, mx_nxt;
  logic           ovf_r, ovf_nxt, sqv_r, sqv_nxt;
  logic [PSW-1:0] sqp_r, sqp_nxt;
  logic [CW-1:0]  ne_r, ne_nxt;
  logic [SUMW-1:0] se_r, se_nxt;
  logic [SQW-1:0] qe_r, qe_nxt;
  logic [PW-1:0]  mc_r, mc_nxt, acc_r, acc_nxt, a_r, a_nxt, b_r, b_nxt;
  logic [SUMW-1:0] mp_r, mp_nxt;
  logic [NNW-1:0] nn_r, nn_nxt, rem_r, rem_nxt, dvs_r, dvs_nxt;
  logic [PW-1:0]  quot_r, quot_nxt, q_r, q_nxt;
  logic [RW:0]    sqrem_r, sqrem_nxt;
  logic [RW-1:0]  root_r, root_nxt, rms_r, rms_nxt, r1_r, r1_nxt;
  logic [SUMW-1:0] mean_r, mean_nxt, gs_r, gs_nxt;
  logic [DW-1:0]  m1_r, m1_nxt, x_r, x_nxt;
  logic [SQW-1:0] gq_r, gq_nxt;
  logic [CW-1:0]  gn_r, gn_nxt;
  logic [PSW-1:0] xsq_r, xsq_nxt;
  logic           keep_r, keep_nxt;
  out_t           out_r, out_nxt;

  logic [SW-1:0]  rdata;
  logic           neg, room, we;
  logic [DW-1:0]  xin, xs;
  logic [PW-1:0]  mul_acc, quot_div;
  logic [NNW:0]   rem_sh, rem_sub;
  logic           div_ge, sq_ge;
  logic [RW+2:0]  sr, trial, sq_sub;
  logic [RW-1:0]  root_step;
  logic [TW-1:0]  diff, thr;

  assign neg  = in_word.sample[SW-1];
  assign xin  = in_word.sample[DW-1:0];
  assign room = nsmp_r < CW'(MAX_SAMPLES);
  assign we   = cmd.take && !neg && room;
  assign xs   = rdata[DW-1:0];

  rmre_ram #(.WIDTH(SW), .DEPTH(MAX_SAMPLES)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (nsmp_r[AW-1:0]),
    .wdata (in_word.sample),
    .raddr (idx_r),
    .rdata (rdata)
  );

  assign mul_acc   = mp_r[0] ? acc_r + mc_r : acc_r;
  assign rem_sh    = {rem_r, quot_r[PW-1]};
  assign div_ge    = rem_sh >= {1'b0, dvs_r};
  assign rem_sub   = rem_sh - {1'b0, dvs_r};
  assign quot_div  = {quot_r[PW-2:0], div_ge};
  assign sr        = {sqrem_r, quot_r[PW-1:PW-2]};
  assign trial     = {1'b0, root_r, 2'b01};
  assign sq_ge     = sr >= trial;
  assign sq_sub    = sr - trial;
  assign root_step = {root_r[RW-2:0], sq_ge};
  assign diff      = TW'(xs) - TW'(m1_r);
  assign thr       = TW'(r1_r) + TW'({r1_r, 1'b0});

  always_comb begin
    run_nxt = run_r;   done_nxt = 1'b0;  oval_nxt = 1'b0;  op_nxt = op_r;
    cnt_nxt = cnt_r;   ph_nxt = ph_r;    idx_nxt = idx_r;  nsmp_nxt = nsmp_r;
    sum_nxt = sum_r;   mx_nxt = mx_r;    ovf_nxt = ovf_r;  sqv_nxt = 1'b0;
    sqp_nxt = sqp_r;   ne_nxt = ne_r;    se_nxt = se_r;    qe_nxt = qe_r;
    mc_nxt = mc_r;     acc_nxt = acc_r;  a_nxt = a_r;      b_nxt = b_r;
    mp_nxt = mp_r;     nn_nxt = nn_r;    rem_nxt = rem_r;  dvs_nxt = dvs_r;
    quot_nxt = quot_r; q_nxt = q_r;      sqrem_nxt = sqrem_r;
    root_nxt = root_r; rms_nxt = rms_r;  r1_nxt = r1_r;    mean_nxt = mean_r;
    gs_nxt = gs_r;     m1_nxt = m1_r;    x_nxt = x_r;      gq_nxt = gq_r;
    gn_nxt = gn_r;     xsq_nxt = xsq_r;  keep_nxt = keep_r; out_nxt = out_r;
    sq_nxt = sqv_r ? sq_r + SQW'(sqp_r) : sq_r;

    if (cmd.take && !neg) begin
      if (room) begin
        nsmp_nxt = nsmp_r + 1'b1;
        sum_nxt  = sum_r + SUMW'(xin);
        sqp_nxt  = PSW'(xin) * PSW'(xin);
        sqv_nxt  = 1'b1;
        if (xin > mx_r) begin
          mx_nxt = xin;
        end
      end else begin
        ovf_nxt = 1'b1;
      end
    end

    if (cmd.go) begin
      op_nxt  = cmd.op;
      run_nxt = 1'b1;
      case (cmd.op)
        OP_MX2, OP_MA, OP_MB, OP_NN: begin
          acc_nxt = '0;
          cnt_nxt = ITW'(SUMW - 1);
          case (cmd.op)
            OP_MX2: begin
              mc_nxt = PW'(mx_r);  mp_nxt = SUMW'(mx_r);
            end
            OP_MA: begin
              mc_nxt = PW'(qe_r);  mp_nxt = SUMW'(ne_r);
            end
            OP_MB: begin
              mc_nxt = PW'(se_r);  mp_nxt = se_r;
            end
            default: begin
              mc_nxt = PW'(ne_r);  mp_nxt = SUMW'(ne_r);
            end
          endcase
        end
        OP_DQ: begin
          quot_nxt = (a_r > b_r) ? a_r - b_r : '0;
          dvs_nxt  = nn_r;
          rem_nxt  = '0;
          cnt_nxt  = ITW'(PW - 1);
        end
        OP_DM: begin
          quot_nxt = PW'(se_r);
          dvs_nxt  = NNW'(ne_r);
          rem_nxt  = '0;
          cnt_nxt  = ITW'(PW - 1);
        end
        OP_SQ: begin
          quot_nxt  = q_r;
          sqrem_nxt = '0;
          root_nxt  = '0;
          cnt_nxt   = ITW'(RW - 1);
        end
        OP_CLIP: begin
          ph_nxt  = 2'd0;
          idx_nxt = '0;
        end
        default: begin
        end
      endcase
    end else if (run_r) begin
      case (op_r)
        OP_MX2, OP_MA, OP_MB, OP_NN: begin
          acc_nxt = mul_acc;
          mc_nxt  = {mc_r[PW-2:0], 1'b0};
          mp_nxt  = {1'b0, mp_r[SUMW-1:1]};
          cnt_nxt = cnt_r - 1'b1;
          if (cnt_r == '0) begin
            run_nxt  = 1'b0;
            done_nxt = 1'b1;
            case (op_r)
              OP_MA:   a_nxt = mul_acc;
              OP_MB:   b_nxt = mul_acc;
              OP_NN:   nn_nxt = mul_acc[NNW-1:0];
              default: begin
              end
            endcase
          end
        end
        OP_DQ, OP_DM: begin
          rem_nxt  = div_ge ? rem_sub[NNW-1:0] : rem_sh[NNW-1:0];
          quot_nxt = quot_div;
          cnt_nxt  = cnt_r - 1'b1;
          if (cnt_r == '0) begin
            run_nxt  = 1'b0;
            done_nxt = 1'b1;
            if (op_r == OP_DQ) begin
              q_nxt = quot_div;
            end else begin
              mean_nxt = quot_div[SUMW-1:0];
            end
          end
        end
        OP_SQ: begin
          quot_nxt  = {quot_r[PW-3:0], 2'b00};
          sqrem_nxt = sq_ge ? sq_sub[RW:0] : sr[RW:0];
          root_nxt  = root_step;
          cnt_nxt   = cnt_r - 1'b1;
          if (cnt_r == '0) begin
            run_nxt  = 1'b0;
            done_nxt = 1'b1;
            rms_nxt  = root_step;
          end
        end
        OP_CLIP: begin
          case (ph_r)
            2'd0: ph_nxt = 2'd1;
            2'd1: begin
              x_nxt    = xs;
              xsq_nxt  = PSW'(xs) * PSW'(xs);
              keep_nxt = $signed(diff) <= $signed(thr);
              ph_nxt   = 2'd2;
            end
            default: begin
              if (keep_r) begin
                gs_nxt = gs_r + SUMW'(x_r);
                gq_nxt = gq_r + SQW'(xsq_r);
                gn_nxt = gn_r + 1'b1;
              end
              idx_nxt = idx_r + 1'b1;
              ph_nxt  = 2'd0;
              if (CW'(idx_r) == nsmp_r - 1'b1) begin
                run_nxt  = 1'b0;
                done_nxt = 1'b1;
              end
            end
          endcase
        end
        default: begin
          run_nxt  = 1'b0;
          done_nxt = 1'b1;
          case (op_r)
            OP_LDP: begin
              ne_nxt = nsmp_r;  se_nxt = sum_r;  qe_nxt = sq_r;
            end
            OP_LDT: begin
              ne_nxt = nsmp_r - 1'b1;
              se_nxt = sum_r - SUMW'(mx_r);
              qe_nxt = sq_r - acc_r[SQW-1:0];
            end
            OP_LDC: begin
              ne_nxt = gn_r;  se_nxt = gs_r;  qe_nxt = gq_r;
            end
            OP_SV1: begin
              m1_nxt = mean_r[DW-1:0];
              r1_nxt = rms_r;
              gs_nxt = '0;  gq_nxt = '0;  gn_nxt = '0;
            end
            OP_EMIT: begin
              oval_nxt = 1'b1;
              if (cmd.ok) begin
                out_nxt.status     = ovf_r ? ST_OVF : ST_OK;
                out_nxt.used_count = OCW'(ne_r);
                out_nxt.mean_value = mean_r[DW-1:0];
                out_nxt.rms_value  = rms_r[DW-1:0];
              end else begin
                out_nxt = '{status: ST_EMPTY, default: '0};
              end
              nsmp_nxt = '0;  sum_nxt = '0;  sq_nxt = '0;
              mx_nxt   = '0;  ovf_nxt = 1'b0;
            end
            default: begin
            end
          endcase
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;  done_r <= 1'b0;  oval_r <= 1'b0;  op_r <= OP_LDP;
      cnt_r <= '0;    ph_r <= '0;      idx_r <= '0;     nsmp_r <= '0;
      sum_r <= '0;    sq_r <= '0;      mx_r <= '0;      ovf_r <= 1'b0;
      sqv_r <= 1'b0;
    end else begin
      run_r <= run_nxt;  done_r <= done_nxt;  oval_r <= oval_nxt;  op_r <= op_nxt;
      cnt_r <= cnt_nxt;  ph_r <= ph_nxt;      idx_r <= idx_nxt;    nsmp_r <= nsmp_nxt;
      sum_r <= sum_nxt;  sq_r <= sq_nxt;      mx_r <= mx_nxt;      ovf_r <= ovf_nxt;
      sqv_r <= sqv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sqp_r <= sqp_nxt;    ne_r <= ne_nxt;      se_r <= se_nxt;      qe_r <= qe_nxt;
    mc_r <= mc_nxt;      acc_r <= acc_nxt;    a_r <= a_nxt;        b_r <= b_nxt;
    mp_r <= mp_nxt;      nn_r <= nn_nxt;      rem_r <= rem_nxt;    dvs_r <= dvs_nxt;
    quot_r <= quot_nxt;  q_r <= q_nxt;        sqrem_r <= sqrem_nxt;
    root_r <= root_nxt;  rms_r <= rms_nxt;    r1_r <= r1_nxt;      mean_r <= mean_nxt;
    gs_r <= gs_nxt;      m1_r <= m1_nxt;      x_r <= x_nxt;        gq_r <= gq_nxt;
    gn_r <= gn_nxt;      xsq_r <= xsq_nxt;    keep_r <= keep_nxt;  out_r <= out_nxt;
  end

  assign sts.done    = done_r;
  assign sts.ge1     = nsmp_r != '0;
  assign sts.ge2     = nsmp_r > CW'(1);
  assign sts.gn_zero = gn_r == '0;
  assign out_word    = out_r;
  assign out_valid   = oval_r;
endmodule
`default_nettype wire

// File: hdl/rmre_ctrl.sv
// Controller: mode register and the step sequence of one estimate
`default_nettype none
module rmre_ctrl import rmre_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic       last,
  input  wire logic       cfg_valid,
  input  wire logic [1:0] cfg_data,
  input  wire sts_t       sts,
  output cmd_t            cmd,
  output logic            busy
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FLUSH = 4'd1;
  localparam logic [3:0] S_LDP   = 4'd2;
  localparam logic [3:0] S_LDT   = 4'd3;
  localparam logic [3:0] S_LDC   = 4'd4;
  localparam logic [3:0] S_MX2   = 4'd5;
  localparam logic [3:0] S_MA    = 4'd6;
  localparam logic [3:0] S_MB    = 4'd7;
  localparam logic [3:0] S_NN    = 4'd8;
  localparam logic [3:0] S_DQ    = 4'd9;
  localparam logic [3:0] S_DM    = 4'd10;
  localparam logic [3:0] S_SQ    = 4'd11;
  localparam logic [3:0] S_SV1   = 4'd12;
  localparam logic [3:0] S_CLIP  = 4'd13;
  localparam logic [3:0] S_EMIT  = 4'd14;

  logic [3:0] state_r, state_nxt;
  logic [1:0] mode_r, mode_nxt;
  logic       ok_r, ok_nxt, pass2_r, pass2_nxt, go_r, go_nxt;
  logic       take;
  logic [OPW-1:0] op;

  assign busy = state_r != S_IDLE;
  assign take = start && !busy;

  always_comb begin
    state_nxt = state_r;
    ok_nxt    = ok_r;
    pass2_nxt = pass2_r;
    mode_nxt  = cfg_valid ? cfg_data : mode_r;
    unique case (state_r)
      S_IDLE: begin
        if (take && last) begin
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        pass2_nxt = 1'b0;
        ok_nxt    = 1'b0;
        if ((mode_r == MODE_PLAIN || mode_r == MODE_CLIP) && sts.ge1) begin
          state_nxt = S_LDP;
        end else if (mode_r == MODE_TRUNC && sts.ge2) begin
          state_nxt = S_MX2;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      default: begin
        if (sts.done) begin
          unique case (state_r)
            S_LDP, S_LDT, S_LDC: state_nxt = S_MA;
            S_MX2: state_nxt = S_LDT;
            S_MA:  state_nxt = S_MB;
            S_MB:  state_nxt = S_NN;
            S_NN:  state_nxt = S_DQ;
            S_DQ:  state_nxt = S_DM;
            S_DM:  state_nxt = S_SQ;
            S_SQ: begin
              if (mode_r == MODE_CLIP && !pass2_r) begin
                state_nxt = S_SV1;
              end else begin
                ok_nxt    = 1'b1;
                state_nxt = S_EMIT;
              end
            end
            S_SV1: state_nxt = S_CLIP;
            S_CLIP: begin
              if (sts.gn_zero) begin
                state_nxt = S_EMIT;
              end else begin
                pass2_nxt = 1'b1;
                state_nxt = S_LDC;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
    endcase
    go_nxt = (state_nxt != state_r) && (state_nxt != S_IDLE) && (state_nxt != S_FLUSH);
  end

  always_comb begin
    unique case (state_r)
      S_LDT:   op = OP_LDT;
      S_LDC:   op = OP_LDC;
      S_MX2:   op = OP_MX2;
      S_MA:    op = OP_MA;
      S_MB:    op = OP_MB;
      S_NN:    op = OP_NN;
      S_DQ:    op = OP_DQ;
      S_DM:    op = OP_DM;
      S_SQ:    op = OP_SQ;
      S_SV1:   op = OP_SV1;
      S_CLIP:  op = OP_CLIP;
      S_EMIT:  op = OP_EMIT;
      default: op = OP_LDP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mode_r  <= MODE_TRUNC;
      ok_r    <= 1'b0;
      pass2_r <= 1'b0;
      go_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      ok_r    <= ok_nxt;
      pass2_r <= pass2_nxt;
      go_r    <= go_nxt;
    end
  end

  assign cmd.take = take;
  assign cmd.go   = go_r;
  assign cmd.op   = op;
  assign cmd.ok   = ok_r;
endmodule
`default_nettype wire

// File: hdl/robust_mean_rms_estimator.sv
// Top level of the robust mean and RMS estimator
// Usage:
//   Input: drive in_word and raise start; a word is taken at a clock edge with
//   start high and busy low. Negative samples are skipped. While a set is open
//   busy stays low, so one sample is taken every cycle.
//   The word with last_sample set closes the set: busy rises and the block
//   computes the estimate with a shared shift-add multiplier, a restoring
//   divider and a two-bits-per-step square root, all serial.
//   The divider passes, of 56 steps each, take the longest. An empty set, a
//   truncated set of fewer than two samples, or the invalid mode goes straight
//   to the result word with status empty.
//   Output: out_word is valid for exactly one cycle with out_valid high; the
//   receiver has no back-pressure and must take it then. busy falls after, and
//   the first word of the next set can be taken once busy is low.
//   Config: cfg_data writes mean_mode when cfg_valid is high; cfg_ready is
//   always high. Write only while busy is low and no set is open.
//   Reset: synchronous, active low; mode returns to truncated, accumulators
//   clear. The sample store needs no clearing.
`default_nettype none
module robust_mean_rms_estimator import rmre_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire in_t        in_word,
  output logic            out_valid,
  output out_t            out_word,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_data
);
  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  rmre_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .last      (in_word.last_sample),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy)
  );

  rmre_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cmd       (cmd),
    .sts       (sts),
    .out_word  (out_word),
    .out_valid (out_valid)
  );

`include "robust_mean_rms_estimator_assert.svh"

  `RMRE_ASSERT_NOW(a_out_busy, out_valid, busy, "result word outside busy window")
  `RMRE_ASSERT_NEXT(a_out_pulse, out_valid, !out_valid, "result strobe longer than one cycle")
  `RMRE_ASSERT_NOW(a_empty_zero, out_valid && out_word.status == ST_EMPTY,
    out_word.used_count == '0 && out_word.mean_value == '0 && out_word.rms_value == '0,
    "empty result carries nonzero fields")
  `RMRE_ASSERT_NOW(a_ok_count, out_valid && (out_word.status == ST_OK || out_word.status == ST_OVF),
    out_word.used_count != '0, "estimate with no samples used")
  `RMRE_ASSERT_NEXT(a_busy_drop, out_valid, !busy, "busy held after result word")
endmodule
`default_nettype wire
